// ----- sv/accel_tilt_angle_macros.svh -----
// Assertion helpers shared by the tilt angle RTL.
`ifndef ACCEL_TILT_ANGLE_MACROS_SVH
`define ACCEL_TILT_ANGLE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ACC_TILT_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Condition a that must be followed by condition b in the next cycle.
`define ACC_TILT_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) else $error(msg);

`endif

// ----- sv/acc_tilt_pkg.sv -----
`timescale 1ns / 1ps
package acc_tilt_pkg;

    localparam int SAMPLE_BITS_DEF  = 13;
    localparam int CORDIC_STEPS_DEF = 20;
    localparam int FRAC_BITS        = 20;
    localparam int ANGLE_FRAC       = 30;
    localparam int ANGLE_W          = 33;
    localparam int TENTHS_W         = 11;
    localparam int QUEUE_DEPTH      = 2;

    // tenths = floor(floor(|ang| * 180000 / 2^30) / 314)
    localparam int SCALE_NUM   = 180000;
    localparam int DIV_DEN     = 314;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (1 << RECIP_SHIFT) / DIV_DEN;
    localparam int PROD_W      = 50;
    localparam int QUOT_IN_W   = 20;

    localparam logic signed [TENTHS_W-1:0] TENTHS_MAX = 11'sd900;

    typedef enum logic [1:0] {
        FUNC_Z    = 2'd0,
        FUNC_X    = 2'd1,
        FUNC_Y    = 2'd2,
        FUNC_ZERO = 2'd3
    } func_t;

    typedef struct packed {
        logic                       root_num;
        logic                       fixed;
        logic                       inv;
        logic signed [TENTHS_W-1:0] tenths;
    } ctrl_t;

    // atan(2^-i) in Q30 radians, rounded to nearest
    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd843314857;
            1:       v = 32'd497837829;
            2:       v = 32'd263043837;
            3:       v = 32'd133525159;
            4:       v = 32'd67021687;
            5:       v = 32'd33543516;
            6:       v = 32'd16775851;
            7:       v = 32'd8388437;
            8:       v = 32'd4194283;
            9:       v = 32'd2097149;
            default: v = (32'd1 << ANGLE_FRAC) >> i;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/acc_tilt_front.sv -----
`timescale 1ns / 1ps
module acc_tilt_front #(
    parameter int SAMPLE_BITS = acc_tilt_pkg::SAMPLE_BITS_DEF,
    parameter int TDATA_W     = 40
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [TDATA_W-1:0]        s_tdata,
    input  logic [1:0]                s_tuser,
    output logic                      push,
    input  logic                      q_ready,
    output logic [2*SAMPLE_BITS-1:0]  sum,
    output logic [SAMPLE_BITS-1:0]    other,
    output acc_tilt_pkg::ctrl_t       ctrl
);
    localparam int SB = SAMPLE_BITS;

    logic signed [SB-1:0]   x, y, z, op_a, op_b, op_o;
    logic signed [2*SB-1:0] sq_a, sq_b;
    acc_tilt_pkg::func_t    func;

    logic                   f_valid_reg;
    logic [2*SB-1:0]        sq_a_reg, sq_b_reg;
    logic [SB-1:0]          other_reg;
    acc_tilt_pkg::func_t    func_reg;
    logic                   ab_zero_reg, o_zero_reg;

    assign x    = $signed(s_tdata[SB-1:0]);
    assign y    = $signed(s_tdata[2*SB-1:SB]);
    assign z    = $signed(s_tdata[3*SB-1:2*SB]);
    assign func = acc_tilt_pkg::func_t'(s_tuser);

    // pick the two axes under the root and the lone axis
    always_comb begin
        case (func)
            acc_tilt_pkg::FUNC_Z: begin op_a = x; op_b = y; op_o = z; end
            acc_tilt_pkg::FUNC_X: begin op_a = y; op_b = z; op_o = x; end
            default:              begin op_a = x; op_b = z; op_o = y; end
        endcase
    end

    assign sq_a = op_a * op_a;
    assign sq_b = op_b * op_b;

    assign s_tready = !f_valid_reg || q_ready;
    assign push     = f_valid_reg && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_tready) begin
            f_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            sq_a_reg    <= sq_a;
            sq_b_reg    <= sq_b;
            other_reg   <= op_o;
            func_reg    <= func;
            ab_zero_reg <= (op_a == '0) && (op_b == '0);
            o_zero_reg  <= (op_o == '0);
        end
    end

    assign sum   = sq_a_reg + sq_b_reg;
    assign other = other_reg;

    // classify: selector three, both zero, zero denominator, or CORDIC
    always_comb begin
        ctrl.root_num = (func_reg == acc_tilt_pkg::FUNC_Z);
        ctrl.fixed    = 1'b1;
        ctrl.inv      = 1'b0;
        ctrl.tenths   = '0;
        if (func_reg == acc_tilt_pkg::FUNC_ZERO) begin
            ctrl.tenths = '0;
        end else if (ab_zero_reg && o_zero_reg) begin
            ctrl.inv = 1'b1;
        end else if (func_reg == acc_tilt_pkg::FUNC_Z && o_zero_reg) begin
            ctrl.tenths = acc_tilt_pkg::TENTHS_MAX;
        end else if (func_reg != acc_tilt_pkg::FUNC_Z && ab_zero_reg) begin
            ctrl.tenths = other_reg[SB-1] ? -acc_tilt_pkg::TENTHS_MAX
                                          : acc_tilt_pkg::TENTHS_MAX;
        end else begin
            ctrl.fixed = 1'b0;
        end
    end

endmodule

// ----- sv/acc_tilt_queue.sv -----
`timescale 1ns / 1ps
`include "accel_tilt_angle_macros.svh"
module acc_tilt_queue #(
    parameter int WIDTH = 54
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             q_ready,
    input  logic             pop,
    output logic             q_valid,
    output logic [WIDTH-1:0] pop_data
);
    localparam int DEPTH = acc_tilt_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign q_ready  = (count_reg != CW'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ACC_TILT_ASSERT(a_no_overfill, !(push && !q_ready), "push into full queue")
    `ACC_TILT_ASSERT(a_no_underrun, !(pop && !q_valid), "pop from empty queue")
    `ACC_TILT_ASSERT_NEXT(a_count_track, push && !pop && q_valid, count_reg != '0,
                          "queue count lost an entry")

endmodule

// ----- sv/acc_tilt_back.sv -----
`timescale 1ns / 1ps
`include "accel_tilt_angle_macros.svh"
module acc_tilt_back #(
    parameter int SAMPLE_BITS  = acc_tilt_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = acc_tilt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              pop,
    input  logic [2*SAMPLE_BITS-1:0]          q_sum,
    input  logic [SAMPLE_BITS-1:0]            q_other,
    input  acc_tilt_pkg::ctrl_t               q_ctrl,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [acc_tilt_pkg::TENTHS_W-1:0] m_tenths,
    output logic                              m_inv
);
    localparam int SB    = SAMPLE_BITS;
    localparam int FRAC  = acc_tilt_pkg::FRAC_BITS;
    localparam int NSQ   = SB + FRAC;
    localparam int ROOTW = NSQ;
    localparam int RW    = NSQ + 2;
    localparam int SUMW  = 2 * SB;
    localparam int W     = SB + FRAC + 4;
    localparam int AW    = acc_tilt_pkg::ANGLE_W;
    localparam int TW    = acc_tilt_pkg::TENTHS_W;
    localparam int PRW   = acc_tilt_pkg::PROD_W;
    localparam int QIW   = acc_tilt_pkg::QUOT_IN_W;
    localparam int RSH   = acc_tilt_pkg::RECIP_SHIFT;
    localparam int TPW   = QIW + 17;

    logic en;
    assign en  = !m_valid || m_ready;
    assign pop = en && q_valid;

    // square root, one result bit per stage
    logic [SUMW-1:0]     s_sum_reg   [0:NSQ-1];
    logic [RW-1:0]       s_rem_reg   [0:NSQ-1];
    logic [ROOTW-1:0]    s_root_reg  [0:NSQ-1];
    logic [SB-1:0]       s_other_reg [0:NSQ-1];
    acc_tilt_pkg::ctrl_t s_ctrl_reg  [0:NSQ-1];
    logic                s_valid_reg [0:NSQ-1];

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        localparam int PAIR = NSQ - 1 - k;
        logic [SUMW-1:0]     sum_in;
        logic [RW-1:0]       rem_in, rem_sh, trial;
        logic [ROOTW-1:0]    root_in;
        logic [SB-1:0]       other_in;
        acc_tilt_pkg::ctrl_t ctrl_in;
        logic                valid_in, ge;
        logic [1:0]          two;

        if (k == 0) begin : g_first
            assign sum_in   = q_sum;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign other_in = q_other;
            assign ctrl_in  = q_ctrl;
            assign valid_in = q_valid;
        end else begin : g_rest
            assign sum_in   = s_sum_reg[k-1];
            assign rem_in   = s_rem_reg[k-1];
            assign root_in  = s_root_reg[k-1];
            assign other_in = s_other_reg[k-1];
            assign ctrl_in  = s_ctrl_reg[k-1];
            assign valid_in = s_valid_reg[k-1];
        end

        if (PAIR >= FRAC) begin : g_bits
            assign two = sum_in[2*(PAIR-FRAC) +: 2];
        end else begin : g_zero
            assign two = 2'b00;
        end

        assign rem_sh = {rem_in[RW-3:0], two};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s_valid_reg[k] <= 1'b0;
            end else if (en) begin
                s_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_sum_reg[k]   <= sum_in;
                s_rem_reg[k]   <= ge ? rem_sh - trial : rem_sh;
                s_root_reg[k]  <= {root_in[ROOTW-2:0], ge};
                s_other_reg[k] <= other_in;
                s_ctrl_reg[k]  <= ctrl_in;
            end
        end
    end

    // vectoring CORDIC, one rotation per stage
    logic signed [W-1:0]  c_x_reg     [0:CORDIC_STEPS-1];
    logic signed [W-1:0]  c_y_reg     [0:CORDIC_STEPS-1];
    logic signed [AW-1:0] c_ang_reg   [0:CORDIC_STEPS-1];
    acc_tilt_pkg::ctrl_t  c_ctrl_reg  [0:CORDIC_STEPS-1];
    logic                 c_valid_reg [0:CORDIC_STEPS-1];

    logic signed [W-1:0] root_s, other_q, num0, den0;
    assign root_s  = $signed({{(W-ROOTW){1'b0}}, s_root_reg[NSQ-1]});
    assign other_q = $signed({{(W-SB-FRAC){s_other_reg[NSQ-1][SB-1]}},
                              s_other_reg[NSQ-1], {FRAC{1'b0}}});
    assign num0 = s_ctrl_reg[NSQ-1].root_num ? root_s : other_q;
    assign den0 = s_ctrl_reg[NSQ-1].root_num ? other_q : root_s;

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
        logic signed [W-1:0]  x_in, y_in;
        logic signed [AW-1:0] ang_in, step;
        acc_tilt_pkg::ctrl_t  ctrl_in;
        logic                 valid_in;

        if (j == 0) begin : g_first
            assign x_in     = den0[W-1] ? -den0 : den0;
            assign y_in     = den0[W-1] ? -num0 : num0;
            assign ang_in   = '0;
            assign ctrl_in  = s_ctrl_reg[NSQ-1];
            assign valid_in = s_valid_reg[NSQ-1];
        end else begin : g_rest
            assign x_in     = c_x_reg[j-1];
            assign y_in     = c_y_reg[j-1];
            assign ang_in   = c_ang_reg[j-1];
            assign ctrl_in  = c_ctrl_reg[j-1];
            assign valid_in = c_valid_reg[j-1];
        end

        assign step = $signed({{(AW-32){1'b0}}, acc_tilt_pkg::atan_entry(j)});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                c_valid_reg[j] <= 1'b0;
            end else if (en) begin
                c_valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                c_ctrl_reg[j] <= ctrl_in;
                if (!y_in[W-1]) begin
                    c_x_reg[j]   <= x_in + (y_in >>> j);
                    c_y_reg[j]   <= y_in - (x_in >>> j);
                    c_ang_reg[j] <= ang_in + step;
                end else begin
                    c_x_reg[j]   <= x_in - (y_in >>> j);
                    c_y_reg[j]   <= y_in + (x_in >>> j);
                    c_ang_reg[j] <= ang_in - step;
                end
            end
        end
    end

    // scale to tenths of a degree: multiply, reciprocal, correct
    logic signed [AW-1:0] ang_last;
    logic [AW-1:0]        mag;
    logic [PRW-1:0]       prod_reg;
    logic                 a_neg_reg, b_neg_reg, a_valid_reg, b_valid_reg;
    acc_tilt_pkg::ctrl_t  a_ctrl_reg, b_ctrl_reg;
    logic [QIW-1:0]       b_quot_in_reg;
    logic [TPW-1:0]       b_t_reg;

    assign ang_last = c_ang_reg[CORDIC_STEPS-1];
    assign mag      = ang_last[AW-1] ? AW'(-ang_last) : AW'(ang_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= c_valid_reg[CORDIC_STEPS-1];
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg      <= PRW'(mag[31:0]) * PRW'(acc_tilt_pkg::SCALE_NUM);
            a_neg_reg     <= ang_last[AW-1];
            a_ctrl_reg    <= c_ctrl_reg[CORDIC_STEPS-1];
            b_quot_in_reg <= prod_reg[acc_tilt_pkg::ANGLE_FRAC +: QIW];
            b_t_reg       <= TPW'(prod_reg[acc_tilt_pkg::ANGLE_FRAC +: QIW])
                             * TPW'(acc_tilt_pkg::RECIP);
            b_neg_reg     <= a_neg_reg;
            b_ctrl_reg    <= a_ctrl_reg;
        end
    end

    logic [QIW-1:0]       q0, q1, rem_q;
    logic [TW-1:0]        sat;
    logic signed [TW-1:0] tenths;
    assign q0    = QIW'(b_t_reg >> RSH);
    assign rem_q = b_quot_in_reg - QIW'(q0 * QIW'(acc_tilt_pkg::DIV_DEN));
    assign q1    = (rem_q >= QIW'(acc_tilt_pkg::DIV_DEN)) ? q0 + 1'b1 : q0;
    assign sat   = (q1 > QIW'(acc_tilt_pkg::TENTHS_MAX)) ? acc_tilt_pkg::TENTHS_MAX
                                                        : TW'(q1);
    assign tenths = b_ctrl_reg.fixed ? b_ctrl_reg.tenths
                  : (b_neg_reg ? -$signed(sat) : $signed(sat));

    logic                 m_valid_reg, m_inv_reg;
    logic signed [TW-1:0] m_tenths_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tenths_reg <= tenths;
            m_inv_reg    <= b_ctrl_reg.inv;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_tenths = m_tenths_reg;
    assign m_inv    = m_inv_reg;

    `ACC_TILT_ASSERT(a_inv_zero, !(m_valid && m_inv) || m_tenths == '0,
                     "invalid result with nonzero angle")
    `ACC_TILT_ASSERT(a_range, !m_valid || (m_tenths <= acc_tilt_pkg::TENTHS_MAX &&
                     m_tenths >= -acc_tilt_pkg::TENTHS_MAX), "angle out of range")
    `ACC_TILT_ASSERT_NEXT(a_hold_stall, m_valid && !m_ready,
                          m_valid && $stable(m_tenths), "result changed while held")

endmodule

// ----- sv/accel_tilt_angle.sv -----
`timescale 1ns / 1ps
// channel   dir  tdata (low bit up)                tuser
// s_        in   accel_x, accel_y, accel_z         func
// m_        out  angle_tenths                      invalid
//
// One sample enters per clock and one result leaves per clock when m_tready
// stays high. A result passes the front register, the queue register, SAMPLE_BITS + 20
// square-root stages, CORDIC_STEPS rotation stages, two scale registers and the
// output register; the square-root pipeline makes up most of that path.
// aresetn is synchronous and clears the valid flags, queue pointers and count only.
// A stall at m_tready freezes the back pipeline; the two-entry queue keeps
// s_tready high until the queue and the front register are both full.
module accel_tilt_angle #(
    parameter int SAMPLE_BITS  = acc_tilt_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = acc_tilt_pkg::CORDIC_STEPS_DEF,
    parameter int S_TDATA_W    = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // accel_x, accel_y, accel_z, zero fill
    input  logic [1:0]           s_tuser,   // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // angle_tenths, zero fill
    output logic [0:0]           m_tuser    // invalid
);
    localparam int SB = SAMPLE_BITS;
    localparam int QW = 2 * SB + SB + $bits(acc_tilt_pkg::ctrl_t);

    logic                 push, q_ready, q_valid, pop, m_inv;
    logic [2*SB-1:0]      f_sum, q_sum;
    logic [SB-1:0]        f_other, q_other;
    acc_tilt_pkg::ctrl_t  f_ctrl, q_ctrl;
    logic [QW-1:0]        q_out;
    logic signed [acc_tilt_pkg::TENTHS_W-1:0] m_tenths;

    // classify each request and form the sum of squares
    acc_tilt_front #(.SAMPLE_BITS(SB), .TDATA_W(S_TDATA_W)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .push    (push),
        .q_ready (q_ready),
        .sum     (f_sum),
        .other   (f_other),
        .ctrl    (f_ctrl)
    );

    // decouple front from back
    acc_tilt_queue #(.WIDTH(QW)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data({f_ctrl, f_other, f_sum}),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .pop_data (q_out)
    );

    assign q_sum   = q_out[2*SB-1:0];
    assign q_other = q_out[3*SB-1:2*SB];
    assign q_ctrl  = acc_tilt_pkg::ctrl_t'(q_out[QW-1:3*SB]);

    // square root, CORDIC and scaling
    acc_tilt_back #(.SAMPLE_BITS(SB), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .pop     (pop),
        .q_sum   (q_sum),
        .q_other (q_other),
        .q_ctrl  (q_ctrl),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_tenths(m_tenths),
        .m_inv   (m_inv)
    );

    assign m_tdata = {{(16 - acc_tilt_pkg::TENTHS_W){1'b0}}, m_tenths};
    assign m_tuser = m_inv;

endmodule

// ----- sim/tb_accel_tilt_angle.sv -----
`timescale 1ns / 1ps
module tb_accel_tilt_angle;

    typedef struct {
        logic signed [10:0] tenths;
        logic               inv;
    } angle_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    angle_res_t angle_q[$];
    int         fail_cnt = 0;
    int         cycle_cnt = 0;
    int         send_idle = 0;
    int         recv_idle = 0;

    localparam int CYCLE_LIMIT = 300000;

    always #1 aclk = ~aclk;

    accel_tilt_angle u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // arctangent of 2^-i in Q30 radians
    function automatic longint atan_step(input int i);
        longint tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return tab[i];
        return (longint'(1) << 30) >> i;
    endfunction

    // floor square root of sum in Q20
    function automatic longint root_q20(input longint unsigned sum);
        longint unsigned rem, root, two, trial;
        rem = 0;
        root = 0;
        for (int p = 32; p >= 0; p--) begin
            two = (p >= 20) ? ((sum >> (2 * p - 40)) & 3) : 0;
            rem = (rem << 2) | two;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return longint'(root);
    endfunction

    function automatic angle_res_t tilt_angle(input logic signed [12:0] ax,
                                              input logic signed [12:0] ay,
                                              input logic signed [12:0] az,
                                              input acc_tilt_pkg::func_t fn);
        angle_res_t r;
        longint x, y, z, num, den, cx, cy, dx, dy, ang, mag;
        x = ax;
        y = ay;
        z = az;
        r.tenths = '0;
        r.inv = 1'b0;
        case (fn)
            acc_tilt_pkg::FUNC_Z: begin num = root_q20(x * x + y * y); den = z <<< 20; end
            acc_tilt_pkg::FUNC_X: begin num = x <<< 20; den = root_q20(y * y + z * z); end
            acc_tilt_pkg::FUNC_Y: begin num = y <<< 20; den = root_q20(x * x + z * z); end
            default: begin num = 0; den = 1; end
        endcase
        if (fn == acc_tilt_pkg::FUNC_ZERO) return r;
        if (den == 0 && num == 0) begin
            r.inv = 1'b1;
            return r;
        end
        if (den == 0) begin
            r.tenths = (num < 0) ? -11'sd900 : 11'sd900;
            return r;
        end
        // vectoring rotation toward the positive x axis
        cx = (den < 0) ? -den : den;
        cy = (den < 0) ? -num : num;
        ang = 0;
        for (int i = 0; i < 20; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx; cy -= dy; ang += atan_step(i);
            end else begin
                cx -= dx; cy += dy; ang -= atan_step(i);
            end
        end
        mag = (ang < 0) ? -ang : ang;
        mag = (mag * 180000) / (longint'(314) << 30);
        if (mag > 900) mag = 900;
        r.tenths = 11'((ang < 0) ? -mag : mag);
        return r;
    endfunction

    // Drive one request; entered and left at a falling edge.
    task automatic send_sample(input logic signed [12:0] ax, input logic signed [12:0] ay,
                               input logic signed [12:0] az, input acc_tilt_pkg::func_t fn);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 40'({az, ay, ax});
        s_tuser  <= fn;
        do @(posedge aclk); while (!s_tready);
        angle_q.push_back(tilt_angle(ax, ay, az, fn));
        @(negedge aclk);
    endtask

    task automatic hold_off();
        s_tvalid <= 1'b0;
        while (angle_q.size() != 0) @(negedge aclk);
    endtask

    function automatic logic signed [12:0] rand_axis();
        int m;
        m = $urandom_range(9);
        if (m < 6) return 13'($urandom_range(8191));
        if (m == 6) return 13'($urandom_range(16)) - 13'sd8;
        if (m == 7) return ($urandom_range(1)) ? 13'sd4095 : -13'sd4096;
        return 13'sd0;
    endfunction

    task automatic test_directed();
        send_sample(13'sd0, 13'sd0, 13'sd0, acc_tilt_pkg::FUNC_Z);       // both zero
        send_sample(13'sd0, 13'sd0, 13'sd0, acc_tilt_pkg::FUNC_X);
        send_sample(13'sd0, 13'sd0, 13'sd0, acc_tilt_pkg::FUNC_Y);
        send_sample(13'sd0, 13'sd0, 13'sd0, acc_tilt_pkg::FUNC_ZERO);
        send_sample(13'sd4095, 13'sd4095, 13'sd4095, acc_tilt_pkg::FUNC_ZERO);
        send_sample(13'sd5, 13'sd0, 13'sd0, acc_tilt_pkg::FUNC_Z);       // zero denominators
        send_sample(-13'sd7, 13'sd0, 13'sd0, acc_tilt_pkg::FUNC_X);
        send_sample(13'sd0, -13'sd4096, 13'sd0, acc_tilt_pkg::FUNC_Y);
        send_sample(13'sd0, 13'sd4095, 13'sd0, acc_tilt_pkg::FUNC_Y);
        send_sample(13'sd4095, 13'sd4095, 13'sd4095, acc_tilt_pkg::FUNC_Z);
        send_sample(-13'sd4096, -13'sd4096, -13'sd4096, acc_tilt_pkg::FUNC_Z); // negative den
        send_sample(13'sd100, 13'sd0, -13'sd300, acc_tilt_pkg::FUNC_Z);
        send_sample(-13'sd4096, 13'sd4095, -13'sd4096, acc_tilt_pkg::FUNC_X);
        send_sample(13'sd4095, -13'sd4096, 13'sd4095, acc_tilt_pkg::FUNC_X);
        send_sample(-13'sd4096, -13'sd4096, 13'sd4095, acc_tilt_pkg::FUNC_Y);
        send_sample(13'sd1, 13'sd1, 13'sd1, acc_tilt_pkg::FUNC_X);
        send_sample(13'sd1, 13'sd4095, 13'sd0, acc_tilt_pkg::FUNC_Y);
        send_sample(13'sd0, 13'sd0, 13'sd1, acc_tilt_pkg::FUNC_Z);
        send_sample(13'sd0, 13'sd0, -13'sd1, acc_tilt_pkg::FUNC_Z);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
            send_sample(rand_axis(), rand_axis(), rand_axis(),
                        acc_tilt_pkg::func_t'($urandom_range(3)));
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge aclk) begin
        angle_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (angle_q.size() == 0) begin
                $error("result with no expectation: angle_tenths %0d", $signed(m_tdata[10:0]));
                fail_cnt++;
            end else begin
                e = angle_q.pop_front();
                if (m_tdata[10:0] !== e.tenths) begin
                    $error("angle_tenths expected %0d actual %0d", e.tenths,
                           $signed(m_tdata[10:0]));
                    fail_cnt++;
                end
                if (m_tuser[0] !== e.inv) begin
                    $error("invalid expected %0b actual %0b", e.inv, m_tuser[0]);
                    fail_cnt++;
                end
            end
        end
    end

    // Receiver stalls at random.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        send_idle = 20;
        recv_idle = 73;
        test_random(650);
        hold_off();
        send_idle = 73;
        recv_idle = 20;
        test_random(650);
        send_idle = 0;
        recv_idle = 0;
        test_random(650);
        hold_off();
        repeat (100) @(posedge aclk);
        if (fail_cnt == 0 && angle_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/acc_tilt_pkg.sv
sv/acc_tilt_front.sv
sv/acc_tilt_queue.sv
sv/acc_tilt_back.sv
sv/accel_tilt_angle.sv
sim/tb_accel_tilt_angle.sv
